// ----- hw/rtl/tked_pkg.sv -----
// Shared types and constants for the touch key event detector.
// No dependencies; used by the core, the divider, the checker and the testbench.
package tked_pkg;

   localparam int unsigned RUN_LEN_BITS  = 8;
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned READ_BITS     = 5;
   localparam int unsigned GATE_BITS     = 16;

   localparam logic [READ_BITS-1:0]    MAX_READ            = 5'd16;
   localparam logic [GATE_BITS-1:0]    GATE_RESET          = 16'd50;
   localparam logic [RUN_LEN_BITS-1:0] SAMPLE_COUNT_RESET  = 8'd50;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_TOUCH   = 2'd1,
      EV_RELEASE = 2'd2
   } event_code_type;

   typedef enum logic [1:0] {
      STAT_EVENT    = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_DISABLED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_ENABLE       = 2'd0,
      REG_GATE         = 2'd1,
      REG_SAMPLE_COUNT = 2'd2
   } reg_index_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_READ   = 1'b1
   } req_kind_type;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CMP      = 6'b000010,
      ST_DIV      = 6'b000100,
      ST_RD_START = 6'b001000,
      ST_RD_ADDR  = 6'b010000,
      ST_RD_DATA  = 6'b100000
   } state_type;

endpackage

// ----- hw/rtl/tked_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tked_pkg for the divisor width.
module tked_div #(
   parameter int unsigned DIVIDEND_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DIVIDEND_BITS-1:0]            dividend,
   input  logic [tked_pkg::RUN_LEN_BITS-1:0]   divisor,
   output logic                                done,
   output logic [DIVIDEND_BITS-1:0]            quotient
);

   localparam int unsigned D     = tked_pkg::RUN_LEN_BITS;
   localparam int unsigned CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [D-1:0]             rem_ff, rem_in;
   logic [D-1:0]             dvs_ff, dvs_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [D:0]               rem_sh;
   logic [D:0]               diff;
   logic                     fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
      diff   = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_BITS);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[D-1:0] : rem_sh[D-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/touch_key_event_detector_core.sv -----
// Touch key event detector: baseline tracking, run detection, event FIFO.
// Depends on tked_pkg and tked_div.
//
// One item at a time. A capture sample is accepted, then goes through the
// threshold compare and run update; a sample that completes a run also waits
// for the serial divider that forms the new baseline. A read starts, then
// takes each event with an event memory read and an output register load,
// gives one result when nothing is delivered, and stretches while rsp_ready
// is low. Event memory has no reset sweep; the block is ready right after
// reset.
module touch_key_event_detector_core #(
   parameter int unsigned FIFO_DEPTH  = 16,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   input  logic [tked_pkg::READ_BITS-1:0]       req_read_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_event_code,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tked_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tked_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tked_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned LB     = tked_pkg::RUN_LEN_BITS;
   localparam int unsigned GB     = tked_pkg::GATE_BITS;
   localparam int unsigned RB     = tked_pkg::READ_BITS;
   localparam int unsigned DB     = tked_pkg::CSR_DATA_BITS;
   localparam int unsigned SUM_W  = SAMPLE_BITS + LB;
   localparam int unsigned TH_W   = ((SAMPLE_BITS > GB) ? SAMPLE_BITS : GB) + 1;
   localparam int unsigned PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

   // configuration
   logic          enable_ff, enable_in;
   logic [GB-1:0] gate_ff, gate_in;
   logic [LB-1:0] scount_ff, scount_in;
   tked_pkg::reg_index_type csr_idx;
   logic          csr_wr;

   assign csr_idx    = tked_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      enable_in  = enable_ff;
      gate_in    = gate_ff;
      scount_in  = scount_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         tked_pkg::REG_ENABLE: begin
            csr_prdata = DB'(enable_ff);
            if (csr_wr) enable_in = csr_pwdata[0];
         end
         tked_pkg::REG_GATE: begin
            csr_prdata = DB'(gate_ff);
            if (csr_wr) gate_in = csr_pwdata[GB-1:0];
         end
         tked_pkg::REG_SAMPLE_COUNT: begin
            csr_prdata = DB'(scount_ff);
            if (csr_wr) scount_in = csr_pwdata[LB-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   // detector and fifo state
   tked_pkg::state_type    state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [RB-1:0]          want_ff, want_in;
   logic [RB-1:0]          rd_cnt_ff, rd_cnt_in;
   logic [SAMPLE_BITS-1:0] baseline_ff, baseline_in;
   logic                   base_valid_ff, base_valid_in;
   logic [SUM_W-1:0]       run_sum_ff, run_sum_in;
   logic [LB-1:0]          run_len_ff, run_len_in;
   logic [1:0]             run_dir_ff, run_dir_in;
   logic [1:0]             last_rep_ff, last_rep_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_code_ff, rsp_code_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [1:0]             event_mem [FIFO_DEPTH];
   logic [1:0]             rd_data_ff;

   logic                   push_en, pop_en, out_free, div_start, div_done;
   logic [SUM_W-1:0]       div_quo;
   logic [TH_W-1:0]        upper, lower, samp_x, base_x, gate_x;
   logic [1:0]             dir;
   logic [LB-1:0]          need, new_len;
   logic [SUM_W-1:0]       new_sum;
   logic                   last_evt;

   assign req_ready = (state_ff == tked_pkg::ST_IDLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      samp_x  = TH_W'(sample_ff);
      base_x  = TH_W'(baseline_ff);
      gate_x  = TH_W'(gate_ff);
      upper   = base_x + gate_x;
      lower   = (base_x > gate_x) ? (base_x - gate_x) : '0;
      need    = (scount_ff == '0) ? LB'(1) : scount_ff;
      if (samp_x > upper)      dir = tked_pkg::EV_TOUCH;
      else if (samp_x < lower) dir = tked_pkg::EV_RELEASE;
      else                     dir = tked_pkg::EV_NONE;
      new_len = ((run_dir_ff == dir) ? run_len_ff : '0) + LB'(1);
      new_sum = ((run_dir_ff == dir) ? run_sum_ff : '0) + SUM_W'(sample_ff);
      last_evt = (rd_cnt_ff == want_ff) || (fill_ff == '0);
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      want_in       = want_ff;
      rd_cnt_in     = rd_cnt_ff;
      baseline_in   = baseline_ff;
      base_valid_in = base_valid_ff;
      run_sum_in    = run_sum_ff;
      run_len_in    = run_len_ff;
      run_dir_in    = run_dir_ff;
      last_rep_in   = last_rep_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_code_in   = rsp_code_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      push_en       = 1'b0;
      pop_en        = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         tked_pkg::ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               want_in   = (req_read_count > tked_pkg::MAX_READ) ?
                           tked_pkg::MAX_READ : req_read_count;
               rd_cnt_in = '0;
               state_in  = (req_type == tked_pkg::REQ_READ) ?
                           tked_pkg::ST_RD_START : tked_pkg::ST_CMP;
            end
         end
         tked_pkg::ST_CMP: begin
            state_in = tked_pkg::ST_IDLE;
            if (enable_ff) begin
               if (dir == tked_pkg::EV_NONE) begin
                  run_sum_in = '0;
                  run_len_in = '0;
                  run_dir_in = tked_pkg::EV_NONE;
               end else begin
                  run_sum_in = new_sum;
                  run_len_in = new_len;
                  run_dir_in = dir;
                  if (new_len >= need) begin
                     div_start = 1'b1;
                     state_in  = tked_pkg::ST_DIV;
                  end
               end
            end
         end
         tked_pkg::ST_DIV: begin
            if (div_done) begin
               if (base_valid_ff) begin
                  push_en     = (last_rep_ff != run_dir_ff) &&
                                (fill_ff != FILL_W'(FIFO_DEPTH));
                  last_rep_in = run_dir_ff;
               end
               baseline_in   = div_quo[SAMPLE_BITS-1:0];
               base_valid_in = 1'b1;
               run_sum_in    = '0;
               run_len_in    = '0;
               state_in      = tked_pkg::ST_IDLE;
            end
         end
         tked_pkg::ST_RD_START: begin
            if (out_free) begin
               if (!enable_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_code_in   = tked_pkg::EV_NONE;
                  rsp_status_in = tked_pkg::STAT_DISABLED;
                  rsp_last_in   = 1'b1;
                  state_in      = tked_pkg::ST_IDLE;
               end else if (want_ff == '0 || fill_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_code_in   = tked_pkg::EV_NONE;
                  rsp_status_in = tked_pkg::STAT_EMPTY;
                  rsp_last_in   = 1'b1;
                  state_in      = tked_pkg::ST_IDLE;
               end else begin
                  state_in = tked_pkg::ST_RD_ADDR;
               end
            end
         end
         tked_pkg::ST_RD_ADDR: begin
            pop_en    = 1'b1;
            rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
            fill_in   = fill_ff - FILL_W'(1);
            rd_cnt_in = rd_cnt_ff + RB'(1);
            state_in  = tked_pkg::ST_RD_DATA;
         end
         tked_pkg::ST_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = rd_data_ff;
               rsp_status_in = tked_pkg::STAT_EVENT;
               rsp_last_in   = last_evt;
               state_in      = last_evt ? tked_pkg::ST_IDLE : tked_pkg::ST_RD_ADDR;
            end
         end
         default: state_in = tked_pkg::ST_IDLE;
      endcase
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         gate_ff       <= tked_pkg::GATE_RESET;
         scount_ff     <= tked_pkg::SAMPLE_COUNT_RESET;
         state_ff      <= tked_pkg::ST_IDLE;
         base_valid_ff <= 1'b0;
         baseline_ff   <= '0;
         run_sum_ff    <= '0;
         run_len_ff    <= '0;
         run_dir_ff    <= tked_pkg::EV_NONE;
         last_rep_ff   <= tked_pkg::EV_NONE;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         gate_ff       <= gate_in;
         scount_ff     <= scount_in;
         state_ff      <= state_in;
         base_valid_ff <= base_valid_in;
         baseline_ff   <= baseline_in;
         run_sum_ff    <= run_sum_in;
         run_len_ff    <= run_len_in;
         run_dir_ff    <= run_dir_in;
         last_rep_ff   <= last_rep_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      want_ff       <= want_in;
      rd_cnt_ff     <= rd_cnt_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // event memory, registered read
   always_ff @(posedge clock) begin
      if (push_en) event_mem[wr_ptr_ff] <= run_dir_ff;
      if (pop_en)  rd_data_ff <= event_mem[rd_ptr_ff];
   end

   tked_div #(
      .DIVIDEND_BITS (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sum),
      .divisor  (new_len),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- hw/rtl/tked_checker.sv -----
// Port-level checks for the touch key event detector core.
// Depends on tked_pkg; bound to touch_key_event_detector_core.
module tked_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_event_code,
   input logic [1:0]                     rsp_status,
   input logic                           rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) &&
      $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // one item in flight: ready is low in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   a_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tked_pkg::STAT_EMPTY ||
                    rsp_status == tked_pkg::STAT_DISABLED)
      |-> rsp_last && rsp_event_code == tked_pkg::EV_NONE)
      else $error("refusal result malformed");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tked_pkg::STAT_EVENT
      |-> rsp_event_code == tked_pkg::EV_TOUCH ||
          rsp_event_code == tked_pkg::EV_RELEASE)
      else $error("delivered event has no direction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == tked_pkg::STAT_EVENT ||
                    rsp_status == tked_pkg::STAT_EMPTY ||
                    rsp_status == tked_pkg::STAT_DISABLED)
      else $error("undefined status");

endmodule

bind touch_key_event_detector_core tked_checker u_tked_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code),
   .rsp_status     (rsp_status),
   .rsp_last       (rsp_last)
);

// ----- dv/touch_key_event_detector_core_tb.sv -----
// Testbench for touch_key_event_detector_core: a self-checking run of capture
// samples and event reads over several register settings, with random idling.
// Depends on tked_pkg and the RTL of the core; reads no files.
`timescale 1ns / 100ps

module touch_key_event_detector_core_tb;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_WAIT  = 40;
   localparam int unsigned LONG_HOLD   = 300;

   typedef struct {
      tked_pkg::req_kind_type   kind;
      logic [15:0]              smp;
      logic [4:0]               cnt;
   } key_req_type;

   typedef struct {
      tked_pkg::event_code_type code;
      tked_pkg::status_type     stat;
      logic                     last;
   } key_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [15:0] req_sample = '0;
   logic [4:0]  req_read_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_code;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [tked_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [tked_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [tked_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   // register mirror
   logic        cfg_en = 1'b0;
   logic [15:0] cfg_gate = tked_pkg::GATE_RESET;
   logic [7:0]  cfg_cnt = tked_pkg::SAMPLE_COUNT_RESET;

   // detector state as seen by the predictor
   logic [15:0]              key_base = '0;
   bit                       key_base_set = 1'b0;
   logic [23:0]              run_acc = '0;
   logic [7:0]               run_len = '0;
   tked_pkg::event_code_type run_dir = tked_pkg::EV_NONE;
   tked_pkg::event_code_type last_dir = tked_pkg::EV_NONE;
   tked_pkg::event_code_type pending_events[$];

   key_req_type req_backlog[$];
   key_rsp_type due_results[$];
   key_req_type cur_req;

   int unsigned queued = 0;
   int unsigned sent = 0;
   int unsigned rsp_total = 0;
   int unsigned ev_total = 0;
   int unsigned mismatches = 0;
   int unsigned n_setups = 0;
   int unsigned cycle_cnt = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned rx_count = 0;
   bit          hold_done = 1'b0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;

   touch_key_event_detector_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_sample     (req_sample),
      .req_read_count (req_read_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   // baseline tracking, run detection and event queue for one transfer
   task automatic compute_key_response(input key_req_type r);
      logic [16:0]              upper;
      logic [15:0]              lower;
      logic [7:0]               need;
      tked_pkg::event_code_type dir;
      key_rsp_type              o;
      int unsigned              want;
      int unsigned              n;
      if (r.kind == tked_pkg::REQ_SAMPLE) begin
         if (!cfg_en) return;
         upper = {1'b0, key_base} + {1'b0, cfg_gate};
         lower = (key_base > cfg_gate) ? key_base - cfg_gate : '0;
         need = (cfg_cnt == 0) ? 8'd1 : cfg_cnt;
         if ({1'b0, r.smp} > upper) dir = tked_pkg::EV_TOUCH;
         else if (r.smp < lower) dir = tked_pkg::EV_RELEASE;
         else dir = tked_pkg::EV_NONE;
         if (dir == tked_pkg::EV_NONE) begin
            run_acc = '0;
            run_len = '0;
            run_dir = tked_pkg::EV_NONE;
            return;
         end
         if (run_dir != dir) begin
            run_acc = '0;
            run_len = '0;
            run_dir = dir;
         end
         run_len = run_len + 8'd1;
         run_acc = run_acc + 24'(r.smp);
         if (run_len >= need) begin
            if (key_base_set) begin
               if (last_dir != run_dir && pending_events.size() < 16)
                  pending_events.push_back(run_dir);
               last_dir = run_dir;
            end
            key_base = 16'(run_acc / run_len);
            key_base_set = 1'b1;
            run_acc = '0;
            run_len = '0;
         end
         return;
      end
      if (!cfg_en) begin
         o = '{tked_pkg::EV_NONE, tked_pkg::STAT_DISABLED, 1'b1};
         due_results.push_back(o);
         return;
      end
      want = (r.cnt > tked_pkg::MAX_READ) ? tked_pkg::MAX_READ : r.cnt;
      n = 0;
      while (n < want && pending_events.size() != 0) begin
         o.code = pending_events.pop_front();
         o.stat = tked_pkg::STAT_EVENT;
         o.last = (n + 1 == want) || (pending_events.size() == 0);
         due_results.push_back(o);
         n++;
      end
      if (n == 0) begin
         o = '{tked_pkg::EV_NONE, tked_pkg::STAT_EMPTY, 1'b1};
         due_results.push_back(o);
      end
   endtask

   // sender
   always @(posedge clock) begin : req_drive
      key_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            compute_key_response(cur_req);
            sent++;
         end
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            cur_req <= nxt;
            req_type <= nxt.kind;
            req_sample <= nxt.smp;
            req_read_count <= nxt.cnt;
            req_valid <= 1'b1;
            gap_left <= tx_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 29) == 0) tx_calm <= ~tx_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off while a read is in progress
   always @(posedge clock) begin : rsp_accept
      int unsigned wait_n;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_valid && rx_count >= 30) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rx_count++;
            wait_n = rx_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 29) == 0) rx_calm <= ~rx_calm;
         end else begin
            wait_n = stall_left;
         end
         if (wait_n != 0) begin
            stall_left <= wait_n - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall_left <= 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      key_rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_total++;
         if (rsp_status == tked_pkg::STAT_EVENT) ev_total++;
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result code %0d status %0d last %0d",
                     $time, rsp_event_code, rsp_status, rsp_last);
         end else begin
            exp_r = due_results.pop_front();
            if (rsp_event_code !== exp_r.code) begin
               mismatches++;
               $display("%0t ns: event_code expected %0d, got %0d",
                        $time, exp_r.code, rsp_event_code);
            end
            if (rsp_status !== exp_r.stat) begin
               mismatches++;
               $display("%0t ns: status expected %0d, got %0d",
                        $time, exp_r.stat, rsp_status);
            end
            if (rsp_last !== exp_r.last) begin
               mismatches++;
               $display("%0t ns: last expected %0d, got %0d",
                        $time, exp_r.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results still due", $time, due_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_sample(input logic [15:0] s);
      req_backlog.push_back('{tked_pkg::REQ_SAMPLE, s, 5'($urandom)});
      queued++;
   endtask

   task automatic queue_read(input logic [4:0] n);
      req_backlog.push_back('{tked_pkg::REQ_READ, 16'($urandom), n});
      queued++;
   endtask

   task automatic csr_write(input tked_pkg::reg_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         tked_pkg::REG_ENABLE:       cfg_en = val[0];
         tked_pkg::REG_GATE:         cfg_gate = val[15:0];
         tked_pkg::REG_SAMPLE_COUNT: cfg_cnt = val[7:0];
         default: ;
      endcase
   endtask

   // wait until all transfers are taken and answered, then let the divider finish
   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // one run of samples on one side of the level; lvl follows the new baseline when the run completes
   task automatic queue_run(input bit up, input int unsigned len, input int unsigned need,
                            inout int unsigned lvl);
      int unsigned lo;
      int unsigned hi;
      int unsigned spread;
      int unsigned acc;
      int unsigned s;
      spread = $urandom_range(0, 400);
      acc = 0;
      for (int unsigned i = 0; i < len; i++) begin
         if (up) begin
            lo = lvl + cfg_gate + 1;
            hi = (lo + spread > 65535) ? 65535 : lo + spread;
         end else begin
            hi = lvl - cfg_gate - 1;
            lo = (hi > spread) ? hi - spread : 0;
         end
         s = $urandom_range(hi, lo);
         acc += s;
         queue_sample(16'(s));
      end
      if (len >= need) lvl = acc / len;
   endtask

   task automatic random_phase(input int unsigned n_items);
      int unsigned lvl;
      int unsigned need;
      int unsigned len;
      int unsigned stop;
      bit          up_ok;
      bit          dn_ok;
      bit          go_up;
      lvl = 32'(key_base);
      need = (cfg_cnt == 0) ? 1 : 32'(cfg_cnt);
      stop = queued + n_items;
      while (queued < stop) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               up_ok = lvl + cfg_gate < 65535;
               dn_ok = lvl > cfg_gate;
               if (!up_ok && !dn_ok) begin
                  queue_sample(16'($urandom));
               end else begin
                  go_up = up_ok && (!dn_ok || $urandom_range(0, 1));
                  len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, need) : need;
                  queue_run(go_up, len, need, lvl);
               end
            end
            6, 7: queue_read(5'($urandom_range(0, 31)));
            8: queue_sample(16'($urandom));
            default: queue_sample(16'(lvl));
         endcase
      end
   endtask

   initial begin
      logic [31:0] gate_val;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset
      queue_read(5'd5);
      queue_sample(16'hFFFF);
      settle();
      csr_write(tked_pkg::REG_ENABLE, 32'd1);
      queue_sample(16'd1000);
      queue_read(5'd0);
      settle();
      // run already started when the count drops to zero (counts as one)
      csr_write(tked_pkg::REG_GATE, 32'd0);
      csr_write(tked_pkg::REG_SAMPLE_COUNT, 32'd0);
      queue_sample(16'd3000);
      queue_sample(16'd2000);
      queue_sample(16'd0);
      queue_sample(16'd0);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'd40000);
      queue_sample(16'd30000);
      queue_read(5'd31);
      queue_read(5'd16);
      queue_sample(16'hFFFF);
      queue_sample(16'd0);
      queue_read(5'd1);
      queue_read(5'd2);
      settle();
      csr_write(tked_pkg::REG_GATE, 32'd65535);
      csr_write(tked_pkg::REG_SAMPLE_COUNT, 32'd255);
      queue_sample(16'd0);
      queue_sample(16'hFFFF);
      queue_read(5'd16);
      settle();
      csr_write(tked_pkg::REG_ENABLE, 32'd0);
      queue_read(5'd0);
      queue_sample(16'd12345);
      n_setups = 5;

      for (int ph = 0; ph < 10; ph++) begin
         settle();
         n_setups++;
         if (ph == 5) begin
            // alternate touch and release until the event queue overflows
            csr_write(tked_pkg::REG_ENABLE, 32'd1);
            csr_write(tked_pkg::REG_GATE, $urandom_range(0, 20));
            csr_write(tked_pkg::REG_SAMPLE_COUNT, 32'd1);
            repeat (10) begin
               queue_sample(16'($urandom_range(50000, 65535)));
               queue_sample(16'($urandom_range(0, 10000)));
            end
            queue_read(5'd16);
            queue_read(5'd31);
            queue_read(5'd3);
         end else begin
            case ($urandom_range(0, 7))
               0: gate_val = 0;
               1: gate_val = 65535;
               2: gate_val = $urandom_range(0, 65535);
               default: gate_val = $urandom_range(1, 300);
            endcase
            csr_write(tked_pkg::REG_ENABLE, 32'($urandom_range(0, 7) != 0));
            csr_write(tked_pkg::REG_GATE, gate_val);
            csr_write(tked_pkg::REG_SAMPLE_COUNT, $urandom_range(1, 5));
            random_phase(29);
         end
      end
      settle();

      $display("%0d requests, %0d results (%0d events) across %0d register setups",
               sent, rsp_total, ev_total, n_setups);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- touch_key_event_detector_core.f -----
hw/rtl/tked_pkg.sv
hw/rtl/tked_div.sv
hw/rtl/touch_key_event_detector_core.sv
hw/rtl/tked_checker.sv
dv/touch_key_event_detector_core_tb.sv
